// ===== src/fba_pkg.sv =====
// Shared types, codes and helpers for the frame bitmap allocator.
// No dependencies; imported by every module of the block.
package fba_pkg;

  localparam int WORD_BITS   = 32;
  localparam int WORD_IDX_W  = 5;
  localparam int FRAME_W     = 20;
  localparam int PADDR_W     = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_MAP   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MAP,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t                  operation;
    logic [FRAME_W-1:0]   entry_frame;
    logic                 kernel_mode;
    logic                 rw_allowed;
    logic [PADDR_W-1:0]   physical_address;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 present;
    logic                 writable;
    logic                 user_access;
    logic [FRAME_W-1:0]   frame_number;
  } res_t;

  // index of the lowest clear bit; only meaningful when one exists
  function automatic logic [WORD_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = WORD_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== src/fba_bitmap_ram.sv =====
// Single-port bitmap memory, one 32-bit word per 32 frames, registered read.
// Depends on fba_pkg for the word width.
module fba_bitmap_ram
  import fba_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fba_ctrl.sv =====
// Request sequencer: clearing pass, first-fit scan, read-modify-write of bitmap words.
// Depends on fba_pkg; drives the port of fba_bitmap_ram.
module fba_ctrl
  import fba_pkg::*;
#(
  parameter int FRAME_COUNT  = 1024,
  parameter int BITMAP_WORDS = 32,
  parameter int AW           = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  output logic                 ram_en,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_addr,
  output logic [WORD_BITS-1:0] ram_wdata,
  input  logic [WORD_BITS-1:0] ram_rdata
);

  localparam logic [AW-1:0]      LAST_WORD = AW'(BITMAP_WORDS - 1);
  localparam logic [FRAME_W-1:0] FRAME_LIM = FRAME_W'(FRAME_COUNT);

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           word_r, word_nxt;
  logic [WORD_IDX_W-1:0]   bit_r, bit_nxt;
  logic                    kern_r, kern_nxt;
  logic                    wr_r, wr_nxt;
  status_t                 status_r, status_nxt;
  logic [FRAME_W-1:0]      frame_r, frame_nxt;

  logic [FRAME_W-1:0]      map_frame;
  logic [AW-1:0]           map_word;
  logic                    map_ok;
  logic                    skip;
  logic                    word_full;
  logic [WORD_IDX_W-1:0]   zb;
  logic [FRAME_W-1:0]      scan_frame;
  logic                    scan_ok;
  logic                    scan_last;

  assign map_frame  = in_req.physical_address[PADDR_W-1:FRAME_SHIFT];
  assign map_word   = map_frame[AW+WORD_IDX_W-1:WORD_IDX_W];
  assign map_ok     = map_frame < FRAME_LIM;
  assign skip       = in_req.entry_frame != '0;
  assign word_full  = ram_rdata == '1;
  assign zb         = lowest_zero(ram_rdata);
  assign scan_frame = FRAME_W'({word_r, zb});
  assign scan_ok    = !word_full && (scan_frame < FRAME_LIM);
  assign scan_last  = word_r == LAST_WORD;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (scan_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (skip) begin
            state_nxt = S_RESULT;
          end else if (in_req.operation == OP_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (map_ok) begin
            state_nxt = S_MAP;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        if (!word_full || scan_last) state_nxt = S_RESULT;
      end
      S_MAP: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = word_r;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        ram_en   = in_valid && !skip && (in_req.operation == OP_ALLOC || map_ok);
        ram_addr = (in_req.operation == OP_ALLOC) ? '0 : map_word;
      end
      S_SCAN: begin
        if (scan_ok) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << zb);
        end else if (word_full && !scan_last) begin
          ram_en   = 1'b1;
          ram_addr = word_r + AW'(1);
        end
      end
      S_MAP: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_r);
      end
      S_RESULT: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    word_nxt   = word_r;
    bit_nxt    = bit_r;
    kern_nxt   = kern_r;
    wr_nxt     = wr_r;
    status_nxt = status_r;
    frame_nxt  = frame_r;
    case (state_r)
      S_CLEAR: begin
        word_nxt = word_r + AW'(1);
      end
      S_IDLE: begin
        kern_nxt  = in_req.kernel_mode;
        wr_nxt    = in_req.rw_allowed;
        bit_nxt   = map_frame[WORD_IDX_W-1:0];
        frame_nxt = map_frame;
        word_nxt  = (in_req.operation == OP_ALLOC) ? '0 : map_word;
        if (skip) begin
          status_nxt = ST_SKIPPED;
        end else if (in_req.operation == OP_ALLOC || map_ok) begin
          status_nxt = ST_DONE;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      S_SCAN: begin
        frame_nxt = scan_frame;
        if (scan_ok) begin
          status_nxt = ST_DONE;
        end else if (!word_full || scan_last) begin
          status_nxt = ST_FULL;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      word_r  <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r    <= bit_nxt;
    kern_r   <= kern_nxt;
    wr_r     <= wr_nxt;
    status_r <= status_nxt;
    frame_r  <= frame_nxt;
  end

  assign res.status       = status_r;
  assign res.present      = status_r == ST_DONE;
  assign res.writable     = (status_r == ST_DONE) && wr_r;
  assign res.user_access  = (status_r == ST_DONE) && !kern_r;
  assign res.frame_number = (status_r == ST_DONE) ? frame_r : '0;

  a_wb_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_CLEAR) |-> (ram_wdata != '0))
    else $error("bitmap write-back clears word");

  a_scan_wb_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ram_we) |-> (ram_rdata != '1))
    else $error("scan wrote back a full word");

  a_done_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_DONE) |-> (res.frame_number < FRAME_LIM))
    else $error("granted frame beyond bitmap");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_DONE) |-> (!res.present && res.frame_number == '0))
    else $error("failed request carries entry bits");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_ready && !res_valid))
    else $error("handshake during clearing pass");

endmodule

// ===== src/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: one used bit per 4 KiB frame, first-fit allocate and map-physical.
// Top level; depends on fba_pkg, fba_ctrl and fba_bitmap_ram.
// After reset the block clears the bitmap memory, one word per cycle, and takes no request
// until that pass ends. Requests are handled one at a time; a request on an already mapped
// entry or an out-of-range address goes straight to its result, a map-physical passes
// through word read, write-back and result, and an allocate scans bitmap words, one per
// cycle through the memory's single port, up to ceil(FRAME_COUNT/32) words. The result
// sits in an output register, so the next request is taken while the previous result
// waits.
module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int FRAME_COUNT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_frame, kernel_mode, rw_allowed, physical_address
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // present, writable, user_access, frame_number
  output logic [1:0]            out_tuser   // status
);

  localparam int BITMAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  req_t                 req;
  res_t                 res;
  logic                 res_valid;
  logic                 res_ready;
  logic                 ram_en;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r;

  assign req.operation        = op_t'(in_tuser);
  assign req.entry_frame      = in_tdata[19:0];
  assign req.kernel_mode      = in_tdata[20];
  assign req.rw_allowed       = in_tdata[21];
  assign req.physical_address = in_tdata[53:22];

  fba_ctrl #(
    .FRAME_COUNT  (FRAME_COUNT),
    .BITMAP_WORDS (BITMAP_WORDS),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  fba_bitmap_ram #(
    .DEPTH (BITMAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.frame_number, out_res_r.user_access,
                       out_res_r.writable, out_res_r.present};

endmodule

// ===== tb/sv/tb_frame_bitmap_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for frame_bitmap_allocator: directed, random, backpressure and
// exhaustion runs of page-entry requests checked against a local bitmap model.
// Depends on fba_pkg and the frame_bitmap_allocator RTL.
module tb_frame_bitmap_allocator
  import fba_pkg::*;
();

  localparam int FRAMES    = 1024;
  localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  logic [WORD_BITS-1:0] used_map [MAP_WORDS];
  int unsigned          frames_in_use = 0;
  res_t                 entries_due [$];
  int                   error_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   stall_requests = 0;
  int                   stall_served = 0;
  int                   hold_left = 0;

  frame_bitmap_allocator #(.FRAME_COUNT(FRAMES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic req_t make_req(input op_t op, input logic [FRAME_W-1:0] entry,
                                    input logic kern, input logic wr,
                                    input logic [PADDR_W-1:0] addr);
    req_t r;
    r.operation        = op;
    r.entry_frame      = entry;
    r.kernel_mode      = kern;
    r.rw_allowed       = wr;
    r.physical_address = addr;
    return r;
  endfunction

  function automatic bit frame_used(input int unsigned f);
    return used_map[f[WORD_IDX_W +: MAP_AW]][f[WORD_IDX_W-1:0]];
  endfunction

  function automatic void mark_frame(input int unsigned f);
    if (!frame_used(f)) begin
      used_map[f[WORD_IDX_W +: MAP_AW]][f[WORD_IDX_W-1:0]] = 1'b1;
      frames_in_use++;
    end
  endfunction

  // expected page entry for one request; updates the bitmap copy
  function automatic res_t predict_entry(input req_t r);
    res_t        e;
    int unsigned f;
    bit          granted;
    e = '0;
    f = 0;
    granted = 1'b0;
    if (r.entry_frame != '0) begin
      e.status = ST_SKIPPED;
    end else if (r.operation == OP_ALLOC) begin
      if (frames_in_use >= FRAMES) begin
        e.status = ST_FULL;
      end else begin
        while (frame_used(f)) f++;
        granted = 1'b1;
      end
    end else begin
      f = r.physical_address >> FRAME_SHIFT;
      if (f < FRAMES) granted = 1'b1;
      else e.status = ST_RANGE;
    end
    if (granted) begin
      mark_frame(f);
      e.status       = ST_DONE;
      e.present      = 1'b1;
      e.writable     = r.rw_allowed;
      e.user_access  = ~r.kernel_mode;
      e.frame_number = FRAME_W'(f);
    end
    return e;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.operation    = ($urandom_range(99) < 55) ? OP_ALLOC : OP_MAP;
    r.kernel_mode  = 1'($urandom_range(1));
    r.rw_allowed   = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 85) r.entry_frame = '0;
    else if (pick < 88) r.entry_frame = '1;
    else r.entry_frame = FRAME_W'($urandom_range(1, 32'hFFFFF));
    if ($urandom_range(99) < 75)
      r.physical_address = {20'($urandom_range(FRAMES - 1)), 12'($urandom)};
    else
      r.physical_address = $urandom;
    return r;
  endfunction

  // drive one word and wait for its handshake; expectation is recorded on acceptance
  task automatic issue_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, r.physical_address, r.rw_allowed, r.kernel_mode, r.entry_frame};
    in_tuser  <= r.operation;
    do @(posedge clk); while (!in_tready);
    entries_due.push_back(predict_entry(r));
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (stall_requests != stall_served) begin
      stall_served = stall_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (entries_due.size() == 0) begin
        $error("unexpected word: status %0d data %h", out_tuser, out_tdata);
        error_count++;
      end else begin
        exp_r = entries_due.pop_front();
        check_field("status", 32'(exp_r.status), 32'(out_tuser));
        check_field("present", 32'(exp_r.present), 32'(out_tdata[0]));
        check_field("writable", 32'(exp_r.writable), 32'(out_tdata[1]));
        check_field("user_access", 32'(exp_r.user_access), 32'(out_tdata[2]));
        check_field("frame_number", 32'(exp_r.frame_number),
                    32'(out_tdata[3 +: FRAME_W]));
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    issue_request(make_req(OP_ALLOC, '0, 1'b1, 1'b0, '0));            // frame zero handed out
    issue_request(make_req(OP_ALLOC, '0, 1'b0, 1'b1, '1));
    issue_request(make_req(OP_MAP, '0, 1'b0, 1'b0, 32'h0000_0000));    // map address zero
    issue_request(make_req(OP_MAP, '0, 1'b1, 1'b1, 32'hFFFF_FFFF));    // beyond bitmap
    issue_request(make_req(OP_MAP, '0, 1'b1, 1'b1, FRAMES * 4096 - 1)); // top frame
    issue_request(make_req(OP_MAP, '0, 1'b0, 1'b1, FRAMES * 4096));     // first frame past end
    issue_request(make_req(OP_MAP, '0, 1'b1, 1'b0, 32'h0000_2FFF));
    issue_request(make_req(OP_ALLOC, '1, 1'b1, 1'b1, '1));              // already mapped
    issue_request(make_req(OP_MAP, 20'd1, 1'b0, 1'b0, 32'h0000_5000));
    issue_request(make_req(OP_MAP, 20'h80000, 1'b1, 1'b0, 32'h8000_0000));
    issue_request(make_req(OP_ALLOC, '0, 1'b1, 1'b1, '0));              // skips used frame 2
    issue_request(make_req(OP_ALLOC, '0, 1'b0, 1'b0, 32'h5555_5555));
    issue_request(make_req(OP_MAP, '0, 1'b0, 1'b1, 32'h0003_1ABC));    // frame 49, second word
    issue_request(make_req(OP_MAP, '0, 1'b1, 1'b0, 32'h0001_F000));    // frame 31, word edge
    issue_request(make_req(OP_MAP, '0, 1'b0, 1'b0, 32'h0002_0000));    // frame 32
    issue_request(make_req(OP_ALLOC, '0, 1'b1, 1'b0, 32'hAAAA_AAAA));
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) issue_request(random_request());
  endtask

  // receiver holds off while words keep coming, so the input side must stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests <= stall_requests + 1;
    repeat (12) issue_request(random_request());
  endtask

  task automatic test_exhaustion();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (frames_in_use < FRAMES)
      issue_request(make_req(OP_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             $urandom));
    repeat (4)
      issue_request(make_req(OP_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             $urandom));
    issue_request(make_req(OP_MAP, '0, 1'b0, 1'b1, 32'h0010_0000));
    issue_request(make_req(OP_MAP, '0, 1'b1, 1'b1, 32'h0040_0000));
    issue_request(make_req(OP_ALLOC, 20'd7, 1'b0, 1'b0, '0));
    issue_request(make_req(OP_ALLOC, '0, 1'b0, 1'b0, '0));
  endtask

  initial begin
    foreach (used_map[i]) used_map[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(470, 16, 49);
    test_random(470, 49, 16);
    test_random(470, 0, 0);
    test_backpressure();
    test_exhaustion();
    in_tvalid <= 1'b0;
    wait (entries_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fba_pkg.sv
src/fba_bitmap_ram.sv
src/fba_ctrl.sv
src/frame_bitmap_allocator.sv
tb/sv/tb_frame_bitmap_allocator.sv
